// ===== rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and widths for the barycentric coordinate pipeline
// Word formats, internal widths and divider request/response structs.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int COORD_BITS       = 12;
  localparam int POINT_FRAC_BITS  = 8;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int QUERY_W          = COORD_BITS + POINT_FRAC_BITS;
  localparam int WEIGHT_W         = 32;

  // Edge vectors and query offset
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int DELTA_W  = QUERY_W + 1;
  // Products and cross terms
  localparam int PROD_C_W = 2 * DIFF_W;
  localparam int PROD_X_W = DIFF_W + DELTA_W;
  localparam int CROSS_W  = PROD_C_W + 1;
  localparam int NUM_W    = PROD_X_W + 1;

  // Quotient = |num| * 2^SCALE_SH / |cross|
  localparam int SCALE_SH   = WEIGHT_FRAC_BITS - POINT_FRAC_BITS;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (NUM_W + SCALE_SH + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_W      = DIV_STAGES * DIV_STEP;
  localparam int DVS_W      = CROSS_W;
  localparam int REM_W      = DVS_W + 1;

  localparam logic [WEIGHT_W-1:0] POS_LIMIT = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] NEG_LIMIT = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex1_x;
    logic signed [COORD_BITS-1:0] vertex1_y;
    logic signed [COORD_BITS-1:0] vertex2_x;
    logic signed [COORD_BITS-1:0] vertex2_y;
    logic signed [COORD_BITS-1:0] vertex3_x;
    logic signed [COORD_BITS-1:0] vertex3_y;
    logic signed [QUERY_W-1:0]    query_x;
    logic signed [QUERY_W-1:0]    query_y;
  } in_word_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_edge12;
    logic signed [WEIGHT_W-1:0] weight_edge13;
    logic                       degenerate;
    logic                       saturated;
  } out_word_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
    logic             neg;
  } div_req_t;

  typedef struct packed {
    logic [DVD_W-1:0] quo;
    logic             neg;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/bcc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_div: pipelined unsigned restoring divider
// DIV_STEP quotient bits per stage, DIV_STAGES stages, all advance on en_i.
// ----------------------------------------------------------------------------
module bcc_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  bcc_pkg::div_req_t  req_i,
  output bcc_pkg::div_rsp_t  rsp_o
);
  import bcc_pkg::*;

  // data path only; the valid chain in the top level carries reset
  logic [DVD_W-1:0] dvd_q [DIV_STAGES];
  logic [DVS_W-1:0] dvs_q [DIV_STAGES];
  logic [REM_W-1:0] rem_q [DIV_STAGES];
  logic [DVD_W-1:0] quo_q [DIV_STAGES];
  logic             neg_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DVD_W-1:0] dvd_in, dvd_d, quo_in, quo_d;
    logic [DVS_W-1:0] dvs_in;
    logic [REM_W-1:0] rem_in, rem_d;
    logic             neg_in;

    // stage inputs: request word or previous stage
    if (s == 0) begin : g_first
      assign dvd_in = req_i.dvd;
      assign dvs_in = req_i.dvs;
      assign rem_in = '0;
      assign quo_in = '0;
      assign neg_in = req_i.neg;
    end else begin : g_next
      assign dvd_in = dvd_q[s-1];
      assign dvs_in = dvs_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    // DIV_STEP shift/compare/subtract steps
    always_comb begin
      rem_d = rem_in;
      dvd_d = dvd_in;
      quo_d = quo_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        rem_d = {rem_d[REM_W-2:0], dvd_d[DVD_W-1]};
        dvd_d = {dvd_d[DVD_W-2:0], 1'b0};
        quo_d = {quo_d[DVD_W-2:0], 1'b0};
        if (rem_d >= {1'b0, dvs_in}) begin
          rem_d    = rem_d - {1'b0, dvs_in};
          quo_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[s] <= dvd_d;
        dvs_q[s] <= dvs_in;
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        neg_q[s] <= neg_in;
      end
    end
  end

  assign rsp_o.quo = quo_q[DIV_STAGES-1];
  assign rsp_o.neg = neg_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/barycentric_coords_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_coords_2d: 2-D barycentric weights of a query point
// Pipelined exact fixed-point evaluation, one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries three integer
//   vertices and a Q12.8 query point. Output channel (out_valid_o /
//   out_stall_i / out_word_o) carries the two Q16.16 weights, a degenerate
//   flag and a saturation flag. A word moves when valid is high and stall low.
//   The weights use the identity Gram-ratio = cross(d,e12)/cross(e13,e12), so
//   each weight is one signed cross product divided by the triangle cross
//   product, scaled by 2^8 and truncated toward zero.
//   The pipeline has 4 arithmetic stages, 22 divider stages (two
//   quotient bits each, set by the 44-bit scaled dividend) and an output
//   register. It takes one word per cycle unless the output stalls.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and in_stall_o is raised; nothing is dropped or repeated.
//   Reset clears all valid bits; the block accepts words right after reset.
// ----------------------------------------------------------------------------
module barycentric_coords_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bcc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bcc_pkg::out_word_t out_word_o
);
  import bcc_pkg::*;

  logic en;
  logic out_valid_q;
  out_word_t out_word_q;

  // global advance: hold everything while a finished word is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- stage 1: edge vectors and query offset
  logic signed [DIFF_W-1:0]  ax_d, ay_d, bx_d, by_d, ax_q, ay_q, bx_q, by_q;
  logic signed [DELTA_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic                      v1_q;

  always_comb begin
    ax_d = DIFF_W'(in_word_i.vertex3_x) - DIFF_W'(in_word_i.vertex1_x);
    ay_d = DIFF_W'(in_word_i.vertex3_y) - DIFF_W'(in_word_i.vertex1_y);
    bx_d = DIFF_W'(in_word_i.vertex2_x) - DIFF_W'(in_word_i.vertex1_x);
    by_d = DIFF_W'(in_word_i.vertex2_y) - DIFF_W'(in_word_i.vertex1_y);
    dx_d = DELTA_W'(in_word_i.query_x)
         - (DELTA_W'(in_word_i.vertex1_x) <<< POINT_FRAC_BITS);
    dy_d = DELTA_W'(in_word_i.query_y)
         - (DELTA_W'(in_word_i.vertex1_y) <<< POINT_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
      dx_q <= dx_d; dy_q <= dy_d;
    end
  end

  // ---------------- stage 2: products
  logic signed [PROD_C_W-1:0] p_axby_q, p_aybx_q;
  logic signed [PROD_X_W-1:0] p_dxby_q, p_dybx_q, p_axdy_q, p_aydx_q;
  logic                       v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_axby_q <= PROD_C_W'(ax_q) * PROD_C_W'(by_q);
      p_aybx_q <= PROD_C_W'(ay_q) * PROD_C_W'(bx_q);
      p_dxby_q <= PROD_X_W'(dx_q) * PROD_X_W'(by_q);
      p_dybx_q <= PROD_X_W'(dy_q) * PROD_X_W'(bx_q);
      p_axdy_q <= PROD_X_W'(ax_q) * PROD_X_W'(dy_q);
      p_aydx_q <= PROD_X_W'(ay_q) * PROD_X_W'(dx_q);
    end
  end

  // ---------------- stage 3: cross products
  logic signed [CROSS_W-1:0] cr_q;
  logic signed [NUM_W-1:0]   n13_q, n12_q;
  logic                      v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q  <= CROSS_W'(p_axby_q) - CROSS_W'(p_aybx_q);
      n13_q <= NUM_W'(p_dxby_q) - NUM_W'(p_dybx_q);
      n12_q <= NUM_W'(p_axdy_q) - NUM_W'(p_aydx_q);
    end
  end

  // ---------------- stage 4: magnitudes, signs, divider requests
  logic [CROSS_W-1:0] cr_mag;
  logic [NUM_W-1:0]   n13_mag, n12_mag;
  div_req_t           req13_d, req12_d, req13_q, req12_q;
  logic               dgn4_q, v4_q;

  always_comb begin
    cr_mag  = cr_q[CROSS_W-1] ? CROSS_W'(-cr_q) : CROSS_W'(cr_q);
    n13_mag = n13_q[NUM_W-1] ? NUM_W'(-n13_q) : NUM_W'(n13_q);
    n12_mag = n12_q[NUM_W-1] ? NUM_W'(-n12_q) : NUM_W'(n12_q);
    req13_d.dvd = DVD_W'(n13_mag) << SCALE_SH;
    req13_d.dvs = cr_mag;
    req13_d.neg = n13_q[NUM_W-1] ^ cr_q[CROSS_W-1];
    req12_d.dvd = DVD_W'(n12_mag) << SCALE_SH;
    req12_d.dvs = cr_mag;
    req12_d.neg = n12_q[NUM_W-1] ^ cr_q[CROSS_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      req13_q <= req13_d;
      req12_q <= req12_d;
      dgn4_q  <= (cr_q == '0);
    end
  end

  // ---------------- divider stages
  div_rsp_t rsp13, rsp12;

  bcc_div u_div13 (
    .clk_i  (clk_i),
    .en_i   (en),
    .req_i  (req13_q),
    .rsp_o  (rsp13)
  );

  bcc_div u_div12 (
    .clk_i  (clk_i),
    .en_i   (en),
    .req_i  (req12_q),
    .rsp_o  (rsp12)
  );

  // degenerate flag rides alongside the divider
  logic dgn_q [DIV_STAGES];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dgn_q[0] <= dgn4_q;
      for (int s = 1; s < DIV_STAGES; s++) dgn_q[s] <= dgn_q[s-1];
    end
  end

  // valid bits for all stages
  logic vd_q [DIV_STAGES];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) vd_q[s] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      vd_q[0] <= v4_q;
      for (int s = 1; s < DIV_STAGES; s++) vd_q[s] <= vd_q[s-1];
      out_valid_q <= vd_q[DIV_STAGES-1];
    end
  end

  // ---------------- output: sign, saturation, degenerate override
  logic [WEIGHT_W-1:0] w13, w12;
  logic                s13, s12;
  out_word_t           out_word_d;

  function automatic logic [WEIGHT_W:0] fin(input div_rsp_t r);
    logic [WEIGHT_W-1:0] lim;
    logic                sat;
    logic [WEIGHT_W-1:0] w;
    lim = r.neg ? NEG_LIMIT : POS_LIMIT;
    sat = (r.quo[DVD_W-1:WEIGHT_W] != '0) || (r.quo[WEIGHT_W-1:0] > lim);
    if (sat) w = lim;
    else     w = r.neg ? WEIGHT_W'(-r.quo[WEIGHT_W-1:0]) : r.quo[WEIGHT_W-1:0];
    return {sat, w};
  endfunction

  always_comb begin
    {s13, w13} = fin(rsp13);
    {s12, w12} = fin(rsp12);
    if (dgn_q[DIV_STAGES-1]) begin
      out_word_d.weight_edge12 = '0;
      out_word_d.weight_edge13 = '0;
      out_word_d.degenerate    = 1'b1;
      out_word_d.saturated     = 1'b0;
    end else begin
      out_word_d.weight_edge12 = w12;
      out_word_d.weight_edge13 = w13;
      out_word_d.degenerate    = 1'b0;
      out_word_d.saturated     = s13 | s12;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire
